// ===== rtl/psa_pkg.sv =====
// Types and constants shared by the PSI section assembler modules.
package psa_pkg;

  localparam int unsigned POS_W = 13;
  localparam int unsigned LEN_W = 12;

  // Table ids whose section length field carries only 10 bits
  localparam logic [7:0] TID_PAT = 8'h00;
  localparam logic [7:0] TID_CAT = 8'h02;

  // Masks for the high length nibble of header byte 1
  localparam logic [7:0] LEN_HI_MASK_SHORT = 8'h03;
  localparam logic [7:0] LEN_HI_MASK_FULL  = 8'h0F;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_TABLE    = 13'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI   = 13'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 13'd2;
  localparam logic [POS_W-1:0] POS_EXT_HI   = 13'd3;
  localparam logic [POS_W-1:0] POS_EXT_LO   = 13'd4;
  localparam logic [POS_W-1:0] POS_VERSION  = 13'd5;
  localparam logic [POS_W-1:0] POS_SECT     = 13'd6;
  localparam logic [POS_W-1:0] POS_LAST     = 13'd7;
  localparam logic [POS_W-1:0] POS_PAY_LONG = 13'd8;
  localparam logic [POS_W-1:0] POS_ALL_ONES = '1;

  // Long header bytes counted by the length field (5 header + 4 CRC)
  localparam logic [LEN_W-1:0] LONG_OVERHEAD = 12'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } psa_in_t;

  typedef struct packed {
    logic             in_payload;
    logic             section_done;
    logic             length_error;
    logic [7:0]       table_kind;
    logic             syntax_flag;
    logic [LEN_W-1:0] section_len;
    logic [15:0]      extension_id;
    logic [4:0]       version;
    logic             current_next;
    logic [7:0]       section_num;
    logic [7:0]       last_section_num;
    logic [LEN_W-1:0] payload_len;
  } psa_result_t;

endpackage

// ===== rtl/psi_section_assembler.sv =====
// Path: an accepted byte is held in the input register, then its result is loaded
// into the result register once that register can take it.
// Throughput: one section byte per cycle while out_stall is low; the header capture
// and position compare sit between the input register and the result register.
// Reset: synchronous active-high rst empties both stages, clears all captures and
// the byte position, and leaves the block awaiting a start-flagged byte.
module psi_section_assembler #(
  parameter int unsigned LENGTH_LIMIT = 4093
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        in_payload,
  output logic        section_done,
  output logic        length_error,
  output logic [7:0]  table_kind,
  output logic        syntax_flag,
  output logic [11:0] section_len,
  output logic [15:0] extension_id,
  output logic [4:0]  version,
  output logic        current_next,
  output logic [7:0]  section_num,
  output logic [7:0]  last_section_num,
  output logic [11:0] payload_len
);
  import psa_pkg::*;

  psa_in_t     in_data;
  psa_in_t     held_data;
  logic        held_valid;
  logic        out_ready;
  logic        advance;
  psa_result_t step_result;
  psa_result_t res;

  assign in_data.data_byte     = data_byte;
  assign in_data.section_start = section_start;

  // A held byte is processed when the result register can take it
  assign advance = held_valid && out_ready;

  psa_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .take       (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  psa_parser #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_data),
    .result  (step_result)
  );

  psa_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (step_result),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (res)
  );

  assign in_payload       = res.in_payload;
  assign section_done     = res.section_done;
  assign length_error     = res.length_error;
  assign table_kind       = res.table_kind;
  assign syntax_flag      = res.syntax_flag;
  assign section_len      = res.section_len;
  assign extension_id     = res.extension_id;
  assign version          = res.version;
  assign current_next     = res.current_next;
  assign section_num      = res.section_num;
  assign last_section_num = res.last_section_num;
  assign payload_len      = res.payload_len;

endmodule

// ===== rtl/psa_in_stage.sv =====
// Input register stage of the PSI section assembler.
module psa_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  psa_pkg::psa_in_t in_data,
  output logic             in_stall,
  input  logic             take,
  output logic             held_valid,
  output psa_pkg::psa_in_t held_data
);
  import psa_pkg::*;

  logic load;

  // Stage may refill whenever it is empty or its item moves on
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held_data <= in_data;
    end
  end

endmodule

// ===== rtl/psa_parser.sv =====
// Header capture and byte position tracking for one section byte per cycle while advance is high.
module psa_parser #(
  parameter int unsigned LENGTH_LIMIT = 4093
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  psa_pkg::psa_in_t     item,
  output psa_pkg::psa_result_t result
);
  import psa_pkg::*;

  localparam logic [LEN_W-1:0] LimitVal = LEN_W'(LENGTH_LIMIT);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       table_reg, table_reg_next;
  logic             syntax_reg, syntax_reg_next;
  logic [LEN_W-1:0] length_reg, length_reg_next;
  logic [15:0]      extension_reg, extension_reg_next;
  logic [4:0]       version_reg, version_reg_next;
  logic             current_next_reg, current_next_reg_next;
  logic [7:0]       section_num_reg, section_num_reg_next;
  logic [7:0]       last_section_reg, last_section_reg_next;
  logic             dropping, dropping_next;
  logic             complete, complete_next;

  logic [POS_W-1:0] pos;
  logic [POS_W:0]   pos_wide;
  logic [POS_W:0]   last_pos;
  logic [POS_W:0]   pay_end;
  logic [7:0]       hi_mask;
  logic [7:0]       b;
  logic             active;
  logic             in_pay;
  logic             done;
  logic             err;
  logic [LEN_W-1:0] payload;

  // Next state for one byte
  always_comb begin
    b        = item.data_byte;
    pos      = item.section_start ? POS_TABLE : byte_position + POS_W'(1);
    pos_wide = {1'b0, pos};
    last_pos = {2'b00, length_reg} + (POS_W+1)'(2);
    pay_end  = {2'b00, length_reg};
    hi_mask  = (table_reg == TID_PAT || table_reg == TID_CAT) ?
               LEN_HI_MASK_SHORT : LEN_HI_MASK_FULL;
    active   = item.section_start || pos == POS_TABLE || !(complete || dropping);

    byte_position_next    = byte_position;
    table_reg_next        = table_reg;
    syntax_reg_next       = syntax_reg;
    length_reg_next       = length_reg;
    extension_reg_next    = extension_reg;
    version_reg_next      = version_reg;
    current_next_reg_next = current_next_reg;
    section_num_reg_next  = section_num_reg;
    last_section_reg_next = last_section_reg;
    dropping_next         = dropping;
    complete_next         = complete;
    in_pay                = 1'b0;
    done                  = 1'b0;
    err                   = 1'b0;

    if (active) begin
      byte_position_next = pos;
      if (pos == POS_TABLE) begin
        // New section: clear captures, take the table id
        table_reg_next        = b;
        syntax_reg_next       = 1'b0;
        length_reg_next       = '0;
        extension_reg_next    = '0;
        version_reg_next      = '0;
        current_next_reg_next = 1'b0;
        section_num_reg_next  = '0;
        last_section_reg_next = '0;
        dropping_next         = 1'b0;
        complete_next         = 1'b0;
      end else if (pos == POS_LEN_HI) begin
        syntax_reg_next = b[7];
        length_reg_next = {(b[3:0] & hi_mask[3:0]), 8'h00};
      end else if (pos == POS_LEN_LO) begin
        length_reg_next = length_reg | {4'h0, b};
        if (length_reg_next > LimitVal) begin
          err           = 1'b1;
          dropping_next = 1'b1;
        end else if (length_reg_next == '0) begin
          // Empty section: next byte wraps the position to byte 0
          done               = 1'b1;
          byte_position_next = POS_ALL_ONES;
        end
      end else begin
        if (syntax_reg) begin
          if (pos == POS_EXT_HI) begin
            extension_reg_next = {b, extension_reg[7:0]};
          end else if (pos == POS_EXT_LO) begin
            extension_reg_next = {extension_reg[15:8], b};
          end else if (pos == POS_VERSION) begin
            version_reg_next      = b[5:1];
            current_next_reg_next = b[0];
          end else if (pos == POS_SECT) begin
            section_num_reg_next = b;
          end else if (pos == POS_LAST) begin
            last_section_reg_next = b;
          end
          // CRC bytes are excluded from the payload
          in_pay = (pos >= POS_PAY_LONG) && (pos_wide + (POS_W+1)'(2) <= pay_end);
        end else begin
          in_pay = pos_wide <= last_pos;
        end
        if (pos_wide == last_pos) begin
          done          = 1'b1;
          complete_next = 1'b1;
        end
      end
    end

    // Payload size, saturating for the long header
    if (syntax_reg_next) begin
      payload = (length_reg_next >= LONG_OVERHEAD) ?
                length_reg_next - LONG_OVERHEAD : '0;
    end else begin
      payload = length_reg_next;
    end
  end

  // Result for the byte in flight
  always_comb begin
    result.in_payload       = in_pay;
    result.section_done     = done;
    result.length_error     = err;
    result.table_kind       = table_reg_next;
    result.syntax_flag      = syntax_reg_next;
    result.section_len      = length_reg_next;
    result.extension_id     = extension_reg_next;
    result.version          = version_reg_next;
    result.current_next     = current_next_reg_next;
    result.section_num      = section_num_reg_next;
    result.last_section_num = last_section_reg_next;
    result.payload_len      = payload;
  end

  // Section state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      table_reg        <= '0;
      syntax_reg       <= 1'b0;
      length_reg       <= '0;
      extension_reg    <= '0;
      version_reg      <= '0;
      current_next_reg <= 1'b0;
      section_num_reg  <= '0;
      last_section_reg <= '0;
      dropping         <= 1'b0;
      complete         <= 1'b1;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      table_reg        <= table_reg_next;
      syntax_reg       <= syntax_reg_next;
      length_reg       <= length_reg_next;
      extension_reg    <= extension_reg_next;
      version_reg      <= version_reg_next;
      current_next_reg <= current_next_reg_next;
      section_num_reg  <= section_num_reg_next;
      last_section_reg <= last_section_reg_next;
      dropping         <= dropping_next;
      complete         <= complete_next;
    end
  end

endmodule

// ===== rtl/psa_out_stage.sv =====
// Result register stage of the PSI section assembler.
module psa_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  psa_pkg::psa_result_t result_in,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psa_pkg::psa_result_t result_out
);
  import psa_pkg::*;

  // Free when empty or when the held result transfers this cycle
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== sim/tb_psi_section_assembler.sv =====
// Self-checking testbench for the PSI section assembler: byte stream stimulus and header checks.
import psa_pkg::*;

// Tracks the section header state byte by byte and holds the header reports still to arrive
class section_scoreboard #(int unsigned LIMIT = 4093);
  logic [POS_W-1:0] position      = '0;
  logic [7:0]       table_id      = '0;
  logic             long_syntax   = 1'b0;
  logic [LEN_W-1:0] length_field  = '0;
  logic [15:0]      extension     = '0;
  logic [4:0]       version_no    = '0;
  logic             cur_next      = 1'b0;
  logic [7:0]       sect_no       = '0;
  logic [7:0]       last_sect_no  = '0;
  bit               dropping      = 1'b0;
  bit               awaiting_start = 1'b1;

  psa_result_t header_reports[$];
  int errors;
  int results_checked;
  int transfers_in;
  int live_bytes;
  int sections_closed;
  int oversize_headers;
  int payload_bytes;

  // Advance the header state by one accepted byte and queue the report it causes
  function void note_byte(logic [7:0] b, logic start);
    logic [POS_W-1:0] p;
    logic [7:0] hi;
    psa_result_t rep;
    int pi;
    int li;
    rep = '0;
    transfers_in++;
    p = start ? POS_TABLE : position + 1'b1;
    if (start || p == POS_TABLE || !(awaiting_start || dropping)) begin
      live_bytes++;
      position = p;
      if (p == POS_TABLE) begin
        length_field = '0;
        long_syntax = 1'b0;
        extension = '0;
        version_no = '0;
        cur_next = 1'b0;
        sect_no = '0;
        last_sect_no = '0;
        dropping = 1'b0;
        awaiting_start = 1'b0;
        table_id = b;
      end else if (p == POS_LEN_HI) begin
        hi = b & ((table_id == TID_PAT || table_id == TID_CAT) ?
                  LEN_HI_MASK_SHORT : LEN_HI_MASK_FULL);
        long_syntax = b[7];
        length_field = {hi[3:0], 8'h00};
      end else if (p == POS_LEN_LO) begin
        length_field = length_field | {4'h0, b};
        if (int'(length_field) > LIMIT) begin
          rep.length_error = 1'b1;
          dropping = 1'b1;
          oversize_headers++;
        end else if (length_field == '0) begin
          // empty section: the next byte is byte 0 whatever its flag says
          rep.section_done = 1'b1;
          position = POS_ALL_ONES;
          sections_closed++;
        end
      end else begin
        pi = p;
        li = length_field;
        if (long_syntax) begin
          case (p)
            POS_EXT_HI:  extension[15:8] = b;
            POS_EXT_LO:  extension[7:0] = b;
            POS_VERSION: begin
              version_no = b[5:1];
              cur_next = b[0];
            end
            POS_SECT:    sect_no = b;
            POS_LAST:    last_sect_no = b;
            default: ;
          endcase
          // CRC bytes at the tail are not payload
          rep.in_payload = (p >= POS_PAY_LONG) && (pi + 2 <= li);
        end else begin
          rep.in_payload = (pi <= li + 2);
        end
        if (pi == li + 2) begin
          rep.section_done = 1'b1;
          awaiting_start = 1'b1;
          sections_closed++;
        end
        if (rep.in_payload) payload_bytes++;
      end
    end
    rep.table_kind = table_id;
    rep.syntax_flag = long_syntax;
    rep.section_len = length_field;
    rep.extension_id = extension;
    rep.version = version_no;
    rep.current_next = cur_next;
    rep.section_num = sect_no;
    rep.last_section_num = last_sect_no;
    if (long_syntax)
      rep.payload_len = (length_field >= LONG_OVERHEAD) ? length_field - LONG_OVERHEAD : '0;
    else
      rep.payload_len = length_field;
    header_reports.push_back(rep);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted report with the oldest one outstanding
  function void check_report(psa_result_t got);
    psa_result_t want;
    if (header_reports.size() == 0) begin
      $error("report transfer with nothing outstanding");
      errors++;
      return;
    end
    want = header_reports.pop_front();
    results_checked++;
    compare_field("in_payload", want.in_payload, got.in_payload);
    compare_field("section_done", want.section_done, got.section_done);
    compare_field("length_error", want.length_error, got.length_error);
    compare_field("table_kind", want.table_kind, got.table_kind);
    compare_field("syntax_flag", want.syntax_flag, got.syntax_flag);
    compare_field("section_len", want.section_len, got.section_len);
    compare_field("extension_id", want.extension_id, got.extension_id);
    compare_field("version", want.version, got.version);
    compare_field("current_next", want.current_next, got.current_next);
    compare_field("section_num", want.section_num, got.section_num);
    compare_field("last_section_num", want.last_section_num, got.last_section_num);
    compare_field("payload_len", want.payload_len, got.payload_len);
  endfunction
endclass

module tb_psi_section_assembler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LENGTH_LIMIT = 4093;
  localparam int BYTE_TARGET = 1800;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        in_payload;
  logic        section_done;
  logic        length_error;
  logic [7:0]  table_kind;
  logic        syntax_flag;
  logic [11:0] section_len;
  logic [15:0] extension_id;
  logic [4:0]  version;
  logic        current_next;
  logic [7:0]  section_num;
  logic [7:0]  last_section_num;
  logic [11:0] payload_len;

  bit quiet = 1'b0;
  int cycle_count = 0;
  section_scoreboard #(LENGTH_LIMIT) sb = new;

  psi_section_assembler #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .section_start(section_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .in_payload(in_payload),
    .section_done(section_done),
    .length_error(length_error),
    .table_kind(table_kind),
    .syntax_flag(syntax_flag),
    .section_len(section_len),
    .extension_id(extension_id),
    .version(version),
    .current_next(current_next),
    .section_num(section_num),
    .last_section_num(last_section_num),
    .payload_len(payload_len)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Cycle limit; also sets the quiet stretches where neither side idles
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
      quiet <= ((cycle_count / 600) % 5) == 4;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transfer; valid stays high into the next byte unless a gap follows
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    section_start <= start;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, start);
  endtask

  // Header plus body; a short body leaves the section open for the next start to cut
  task automatic send_section(input logic [7:0] tid, input logic syn, input logic [11:0] len,
                              input bit full, input int cut);
    logic [3:0] hi;
    int eff;
    int body;
    hi = len[11:8];
    eff = len;
    if (tid == TID_PAT || tid == TID_CAT) begin
      // masked high bits carry junk
      hi = {2'($urandom_range(0, 3)), len[9:8]};
      eff = len[9:0];
    end
    body = full ? eff : ((cut < eff) ? cut : eff);
    send_byte(tid, 1'b1);
    send_byte({syn, 3'($urandom_range(0, 7)), hi}, 1'b0);
    send_byte(len[7:0], 1'b0);
    repeat (body) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic wait_all_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.header_reports.size() != 0);
  endtask

  function automatic logic [7:0] pick_table();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return TID_PAT;
    if (r < 35) return TID_CAT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stalls, one long hold-off once traffic is flowing
  initial begin : receiver
    int hold;
    int r;
    bit held_long;
    hold = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && sb.results_checked >= 400) begin
        held_long = 1'b1;
        hold = 300;
      end else if (hold == 0 && !quiet) begin
        r = $urandom_range(0, 99);
        if (r < 20) hold = $urandom_range(1, 3);
        else if (r < 23) hold = $urandom_range(10, 30);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_report({in_payload, section_done, length_error, table_kind, syntax_flag,
                       section_len, extension_id, version, current_next, section_num,
                       last_section_num, payload_len});
  end

  initial begin : stimulus
    int kind;
    logic [7:0] tid;
    logic syn;
    logic [11:0] len;
    bit paused;
    bit big_done;

    paused = 1'b0;
    big_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray byte before any start is ignored
    send_byte(8'hFF, 1'b0);
    // table 0x00 with all-ones header: length masked to 10 bits, full long header
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    // start mid-section cuts it; table 0x02 also masked
    send_byte(8'h02, 1'b1);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFD, 1'b0);
    // length one past the limit: error, then bytes dropped
    send_byte(8'h4E, 1'b1);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    // empty section, next unflagged byte opens a new one
    send_byte(8'h70, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h73, 1'b0);
    // long syntax with the section ending inside the long header
    send_byte(8'h80, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h55, 1'b0);

    // Random sections, cut sections, oversize headers and noise
    while (sb.live_bytes < BYTE_TARGET) begin
      if (!big_done && sb.live_bytes >= 600) begin
        send_section(TID_PAT, 1'($urandom_range(0, 1)), 12'h3FF, 1'b1, 0);
        big_done = 1'b1;
      end
      if (!paused && sb.live_bytes >= 900) begin
        wait_all_reports();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      tid = pick_table();
      syn = 1'($urandom_range(0, 1));
      if (kind < 70) begin
        if ($urandom_range(0, 99) < 85) len = 12'($urandom_range(0, 30));
        else len = 12'($urandom_range(31, 300));
        send_section(tid, syn, len, 1'b1, 0);
        if ($urandom_range(0, 99) < 30)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 80) begin
        if ($urandom_range(0, 3) == 0) len = 12'(LENGTH_LIMIT);
        else len = 12'($urandom_range(0, LENGTH_LIMIT));
        send_section(tid, syn, len, 1'b0, $urandom_range(0, 12));
      end else if (kind < 87) begin
        if (tid == TID_PAT || tid == TID_CAT) tid = 8'h4E;
        send_section(tid, syn, 12'($urandom_range(LENGTH_LIMIT + 1, 4095)), 1'b0,
                     $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end

    wait_all_reports();
    repeat (8) @(posedge clk);
    $display("Covered %0d byte transfers (%0d inside sections), %0d reports checked",
             sb.transfers_in, sb.live_bytes, sb.results_checked);
    $display("Sections closed %0d, oversize headers %0d, payload bytes %0d",
             sb.sections_closed, sb.oversize_headers, sb.payload_bytes);
    if (sb.errors == 0 && sb.header_reports.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
